[src/ssg_pkg.sv]
// shared types, constants and codes of the spectral suppression gain core
// no dependencies
package ssg_pkg;

  localparam int unsigned MAX_HALF_SIZE_DEF = 2048;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned QBITS = 30;
  localparam int unsigned DEN_W = 72;
  localparam int unsigned ROOT_W = QBITS / 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [GAIN_W-1:0] UNITY = 16'h8000;
  localparam logic [IDX_W-1:0] HALF_SIZE_RST = 12'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_MODE = 4'd0,
    CFG_HALF_SIZE = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RULE_WIENER  = 3'd0,
    RULE_POWER   = 3'd1,
    RULE_MAGN    = 3'd2,
    RULE_GATE    = 3'd3,
    RULE_GENERAL = 3'd4
  } rule_t;

  // how the final gain is formed: directly, or from the quotient or its root
  typedef enum logic [1:0] {
    POST_DIRECT = 2'd0,
    POST_QUOT   = 2'd1,
    POST_ROOT   = 2'd2,
    POST_COMP   = 2'd3
  } post_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic [31:0]      bin_power;
    logic [31:0]      noise_level;
    logic [15:0]      over_factor;
    logic [15:0]      floor_factor;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [GAIN_W-1:0] gain;
    logic              last_of_item;
  } out_item_t;

  // control that rides along the arithmetic pipeline
  typedef struct packed {
    post_t             post;
    logic [GAIN_W-1:0] dgain;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  mirror;
    logic              two;
  } side_t;

endpackage

[src/ssg_div.sv]
// pipelined restoring divider, one quotient bit per stage, numerator below divisor
// depends on ssg_pkg
module ssg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [ssg_pkg::DEN_W-1:0] in_num,
  input  logic [ssg_pkg::DEN_W-1:0] in_den,
  input  ssg_pkg::side_t            in_side,
  output logic                      out_vld,
  output logic [ssg_pkg::QBITS-1:0] out_quot,
  output ssg_pkg::side_t            out_side
);

  localparam int unsigned NS = ssg_pkg::QBITS;
  localparam int unsigned W = ssg_pkg::DEN_W;

  logic                      vld_r  [NS+1];
  logic [W-1:0]              rem_r  [NS+1];
  logic [W-1:0]              den_r  [NS+1];
  logic [NS-1:0]             quot_r [NS+1];
  ssg_pkg::side_t            side_r [NS+1];
  logic [W-1:0]              rem_nxt  [NS];
  logic [NS-1:0]             quot_nxt [NS];

  always_comb begin
    logic [W:0] sh;
    for (int i = 0; i < NS; i++) begin
      sh = {rem_r[i], 1'b0};
      if (sh >= {1'b0, den_r[i]}) begin
        rem_nxt[i]  = W'(sh - {1'b0, den_r[i]});
        quot_nxt[i] = {quot_r[i][NS-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = sh[W-1:0];
        quot_nxt[i] = {quot_r[i][NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 0; i < NS; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      quot_r[0] <= '0;
      side_r[0] <= in_side;
      for (int i = 0; i < NS; i++) begin
        rem_r[i+1]  <= rem_nxt[i];
        den_r[i+1]  <= den_r[i];
        quot_r[i+1] <= quot_nxt[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_quot = quot_r[NS];
  assign out_side = side_r[NS];

endmodule

[src/ssg_sqrt.sv]
// pipelined digit-by-digit square root, one root bit per stage
// depends on ssg_pkg
module ssg_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [ssg_pkg::QBITS-1:0]  in_rad,
  input  ssg_pkg::side_t             in_side,
  output logic                       out_vld,
  output logic [ssg_pkg::QBITS-1:0]  out_rad,
  output logic [ssg_pkg::ROOT_W-1:0] out_root,
  output ssg_pkg::side_t             out_side
);

  localparam int unsigned NS = ssg_pkg::ROOT_W;
  localparam int unsigned QW = ssg_pkg::QBITS;
  localparam int unsigned RW = NS + 2;

  logic           vld_r  [NS+1];
  logic [QW-1:0]  rad_r  [NS+1];
  logic [QW-1:0]  sh_r   [NS+1];
  logic [RW-1:0]  rem_r  [NS+1];
  logic [NS-1:0]  root_r [NS+1];
  ssg_pkg::side_t side_r [NS+1];
  logic [RW-1:0]  rem_nxt  [NS];
  logic [NS-1:0]  root_nxt [NS];

  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    for (int i = 0; i < NS; i++) begin
      cur   = {rem_r[i], sh_r[i][QW-1:QW-2]};
      trial = (RW+2)'({root_r[i], 2'b01});
      if (cur >= trial) begin
        rem_nxt[i]  = RW'(cur - trial);
        root_nxt[i] = {root_r[i][NS-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = cur[RW-1:0];
        root_nxt[i] = {root_r[i][NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 0; i < NS; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= in_rad;
      sh_r[0]   <= in_rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
      for (int i = 0; i < NS; i++) begin
        rad_r[i+1]  <= rad_r[i];
        sh_r[i+1]   <= {sh_r[i][QW-3:0], 2'b00};
        rem_r[i+1]  <= rem_nxt[i];
        root_r[i+1] <= root_nxt[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_rad  = rad_r[NS];
  assign out_root = root_r[NS];
  assign out_side = side_r[NS];

endmodule

[src/spectral_suppression_gain_core.sv]
// the first result leaves the output register, the mirrored one follows once the first is taken
// throughput: one bin per cycle through the pipeline unless stalled, one result per cycle at
// the output while out_stall is low, so a mirrored bin can stall the pipeline until both are taken
// the 30-stage divider and 15-stage square root make up most of the latency
// synchronous active-low reset clears valid bits, rule_mode to 0 and half_size to 1024
module spectral_suppression_gain_core #(
  parameter int unsigned MAX_HALF_SIZE = ssg_pkg::MAX_HALF_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ssg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ssg_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IW = ssg_pkg::IDX_W;
  localparam int unsigned W = ssg_pkg::DEN_W;

  logic [2:0]    rule_mode_r;
  logic [IW-1:0] half_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_mode_r <= ssg_pkg::RULE_WIENER;
      half_size_r <= ssg_pkg::HALF_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssg_pkg::CFG_RULE_MODE: rule_mode_r <= cfg_data[2:0];
        ssg_pkg::CFG_HALF_SIZE: half_size_r <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign in_stall = !en;

  // mirror position from the clamped half size
  logic [IW-1:0] h_eff;
  logic [IW:0]   mir_full;
  ssg_pkg::side_t side_in;
  always_comb begin
    h_eff = (32'(half_size_r) > MAX_HALF_SIZE) ? IW'(MAX_HALF_SIZE) : half_size_r;
    mir_full = {h_eff, 1'b0} - {1'b0, in_data.bin_index};
    side_in.post   = ssg_pkg::POST_DIRECT;
    side_in.dgain  = ssg_pkg::UNITY;
    side_in.idx    = in_data.bin_index;
    side_in.mirror = mir_full[IW-1:0];
    side_in.two    = (in_data.bin_index != '0) && (in_data.bin_index < h_eff);
  end

  // stage 1: squares
  logic           s1_vld_r;
  logic [31:0]    s1_p_r, s1_n_r;
  logic [15:0]    s1_a_r, s1_b_r;
  logic [63:0]    s1_p2_r, s1_n2_r;
  logic [2:0]     s1_mode_r;
  ssg_pkg::side_t s1_side_r;
  // stage 2: partial products of alpha and beta with N*N
  logic           s2_vld_r;
  logic [31:0]    s2_p_r, s2_n_r;
  logic [63:0]    s2_p2_r;
  logic [47:0]    s2_alo_r, s2_ahi_r, s2_blo_r, s2_bhi_r;
  logic [2:0]     s2_mode_r;
  ssg_pkg::side_t s2_side_r;
  // stage 3: full products
  logic           s3_vld_r;
  logic [31:0]    s3_p_r, s3_n_r;
  logic [63:0]    s3_p2_r;
  logic [79:0]    s3_an_r, s3_bn_r;
  logic [2:0]     s3_mode_r;
  ssg_pkg::side_t s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r    <= in_data.bin_power;
      s1_n_r    <= in_data.noise_level;
      s1_a_r    <= in_data.over_factor;
      s1_b_r    <= in_data.floor_factor;
      s1_p2_r   <= 64'(in_data.bin_power) * 64'(in_data.bin_power);
      s1_n2_r   <= 64'(in_data.noise_level) * 64'(in_data.noise_level);
      s1_mode_r <= rule_mode_r;
      s1_side_r <= side_in;

      s2_p_r    <= s1_p_r;
      s2_n_r    <= s1_n_r;
      s2_p2_r   <= s1_p2_r;
      s2_alo_r  <= 48'(s1_n2_r[31:0]) * 48'(s1_a_r);
      s2_ahi_r  <= 48'(s1_n2_r[63:32]) * 48'(s1_a_r);
      s2_blo_r  <= 48'(s1_n2_r[31:0]) * 48'(s1_b_r);
      s2_bhi_r  <= 48'(s1_n2_r[63:32]) * 48'(s1_b_r);
      s2_mode_r <= s1_mode_r;
      s2_side_r <= s1_side_r;

      s3_p_r    <= s2_p_r;
      s3_n_r    <= s2_n_r;
      s3_p2_r   <= s2_p2_r;
      s3_an_r   <= {s2_ahi_r, 32'b0} + 80'(s2_alo_r);
      s3_bn_r   <= {s2_bhi_r, 32'b0} + 80'(s2_blo_r);
      s3_mode_r <= s2_mode_r;
      s3_side_r <= s2_side_r;
    end
  end

  // rule selection: everything that needs a quotient becomes num/den with num < den
  logic [W-1:0]   dv_num, dv_den;
  ssg_pkg::side_t dv_side;
  always_comb begin
    logic [W-1:0] lim;
    logic [80:0]  tot;
    lim     = {s3_p2_r, 8'b0};
    tot     = 81'(s3_an_r) + 81'(s3_bn_r);
    dv_num  = '0;
    dv_den  = {{(W-32){1'b0}}, s3_p_r};
    dv_side = s3_side_r;
    dv_side.post  = ssg_pkg::POST_DIRECT;
    dv_side.dgain = ssg_pkg::UNITY;
    case (s3_mode_r)
      ssg_pkg::RULE_WIENER, ssg_pkg::RULE_POWER, ssg_pkg::RULE_MAGN: begin
        if (s3_n_r == '0) begin
          dv_side.dgain = ssg_pkg::UNITY;
        end else if (s3_p_r > s3_n_r) begin
          if (s3_mode_r == ssg_pkg::RULE_WIENER) begin
            dv_side.post = ssg_pkg::POST_QUOT;
            dv_num = W'(s3_p_r - s3_n_r);
          end else if (s3_mode_r == ssg_pkg::RULE_POWER) begin
            dv_side.post = ssg_pkg::POST_ROOT;
            dv_num = W'(s3_p_r - s3_n_r);
          end else begin
            dv_side.post = ssg_pkg::POST_COMP;
            dv_num = W'(s3_n_r);
          end
        end else begin
          dv_side.dgain = '0;
        end
      end
      ssg_pkg::RULE_GATE: begin
        if (s3_n_r != '0 && s3_p_r < s3_n_r) dv_side.dgain = '0;
      end
      ssg_pkg::RULE_GENERAL: begin
        dv_den = lim;
        if (s3_p_r == '0) begin
          dv_side.dgain = ssg_pkg::UNITY;
        end else if (tot < 81'(lim)) begin
          // no subtraction at all gives exactly unity
          if (s3_an_r != '0) begin
            dv_side.post = ssg_pkg::POST_ROOT;
            dv_num = lim - s3_an_r[W-1:0];
          end
        end else if (s3_bn_r < 80'(lim)) begin
          dv_side.post = ssg_pkg::POST_ROOT;
          dv_num = s3_bn_r[W-1:0];
        end
      end
      default: dv_side.dgain = ssg_pkg::UNITY;
    endcase
  end

  logic                        dq_vld;
  logic [ssg_pkg::QBITS-1:0]   dq_quot;
  ssg_pkg::side_t              dq_side;

  ssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_num   (dv_num),
    .in_den   (dv_den),
    .in_side  (dv_side),
    .out_vld  (dq_vld),
    .out_quot (dq_quot),
    .out_side (dq_side)
  );

  logic                        sq_vld;
  logic [ssg_pkg::QBITS-1:0]   sq_rad;
  logic [ssg_pkg::ROOT_W-1:0]  sq_root;
  ssg_pkg::side_t              sq_side;

  ssg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dq_vld),
    .in_rad   (dq_quot),
    .in_side  (dq_side),
    .out_vld  (sq_vld),
    .out_rad  (sq_rad),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  logic [ssg_pkg::GAIN_W-1:0] fin_gain;
  always_comb begin
    case (sq_side.post)
      ssg_pkg::POST_QUOT: fin_gain = ssg_pkg::GAIN_W'(sq_rad[ssg_pkg::QBITS-1:15]);
      ssg_pkg::POST_ROOT: fin_gain = ssg_pkg::GAIN_W'(sq_root);
      ssg_pkg::POST_COMP: fin_gain = ssg_pkg::UNITY - ssg_pkg::GAIN_W'(sq_root);
      default:            fin_gain = sq_side.dgain;
    endcase
  end

  // output register, sends one or two results per bin
  logic                       ov_r;
  logic                       phase_r;
  logic                       two_r;
  logic [IW-1:0]              oidx_r, omir_r;
  logic [ssg_pkg::GAIN_W-1:0] ogain_r;
  logic                       take, done, out_load;

  assign take     = ov_r && !out_stall;
  assign done     = take && (!two_r || phase_r);
  assign out_load = !ov_r || done;
  assign en       = !sq_vld || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else if (out_load) begin
      ov_r    <= sq_vld;
      phase_r <= 1'b0;
    end else if (take) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      two_r   <= sq_side.two;
      oidx_r  <= sq_side.idx;
      omir_r  <= sq_side.mirror;
      ogain_r <= fin_gain;
    end
  end

  assign out_valid = ov_r;
  always_comb begin
    out_data.out_index    = phase_r ? omir_r : oidx_r;
    out_data.gain         = ogain_r;
    out_data.last_of_item = !two_r || phase_r;
  end

endmodule
